// ===== sv/tle_pkg.sv =====
// Shared types and constants for the terminal line editor.
package tle_pkg;

  // Line geometry
  localparam int unsigned LINE_CHARS = 32;
  localparam int unsigned IDX_W      = $clog2(LINE_CHARS);
  localparam int unsigned CNT_W      = $clog2(LINE_CHARS + 1);
  localparam int unsigned ERASE_W    = 6;

  // Character codes
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChBs     = 8'h08;
  localparam logic [7:0] ChKill   = 8'h15;
  localparam logic [7:0] ChWerase = 8'h17;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTilde  = 8'h7E;

  // Result kinds
  typedef enum logic [1:0] {
    KindEcho  = 2'd0,
    KindErase = 2'd1,
    KindCrlf  = 2'd2,
    KindLine  = 2'd3
  } kind_e;

  // One result request from the controller to the output register
  typedef struct packed {
    logic               valid;
    kind_e              kind;
    logic [7:0]         ch;
    logic [ERASE_W-1:0] cnt;
    logic               last;
  } res_t;

  // Line store port request
  typedef struct packed {
    logic             we;
    logic             re;
    logic [IDX_W-1:0] addr;
    logic [7:0]       wdata;
  } mem_req_t;

  // Controller status
  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] fill;
  } status_t;

endpackage

// ===== sv/tle_line_store.sv =====
// Single-port line store with registered read data.
module tle_line_store (
  input  logic              clk_i,
  input  tle_pkg::mem_req_t req_i,
  output logic [7:0]        rdata_o
);
  import tle_pkg::*;

  logic [7:0] mem_q [LINE_CHARS];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
  end

  // read port, registered; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tle_ctrl.sv =====
// Edit sequencer: decodes each byte and reads, modifies and writes the line store.
module tle_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        byte_in_i,
  input  logic              slot_free_i,
  input  logic [7:0]        rdata_i,
  output tle_pkg::mem_req_t mem_req_o,
  output tle_pkg::res_t     res_o,
  output tle_pkg::status_t  status_o
);
  import tle_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StAppLf,
    StRdReq,
    StRdEmit,
    StWwReq,
    StWwChk,
    StWwOut
  } state_e;

  localparam logic [CNT_W-1:0] LineMax = CNT_W'(LINE_CHARS);
  localparam logic [CNT_W-1:0] CntOne  = CNT_W'(1);

  state_e           state_q, state_d;
  logic [7:0]       byte_q, byte_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] len_q, len_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] removed_q, removed_d;
  logic             space_ph_q, space_ph_d;

  logic             is_sp;
  logic             rd_last;
  logic [CNT_W-1:0] fill_m1;

  assign is_sp   = (rdata_i == ChSpace);
  assign rd_last = ({1'b0, idx_q} == (len_q - CntOne));
  assign fill_m1 = fill_q - CntOne;

  // next state and requests
  always_comb begin
    state_d    = state_q;
    byte_d     = byte_q;
    fill_d     = fill_q;
    len_d      = len_q;
    idx_d      = idx_q;
    removed_d  = removed_q;
    space_ph_d = space_ph_q;
    res_o      = '0;
    mem_req_o  = '0;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          byte_d  = byte_in_i;
          state_d = StExec;
        end
      end

      StExec: begin
        if (byte_q == ChLf || byte_q == ChCr) begin
          if (slot_free_i) begin
            res_o.valid = 1'b1;
            res_o.kind  = KindCrlf;
            res_o.last  = (fill_q == '0);
            if (fill_q == '0) begin
              state_d = StIdle;
            end else begin
              len_d   = fill_q;
              state_d = StAppLf;
              // append CR if there is room
              if (fill_q < LineMax) begin
                mem_req_o.we    = 1'b1;
                mem_req_o.addr  = fill_q[IDX_W-1:0];
                mem_req_o.wdata = ChCr;
                len_d           = fill_q + CntOne;
              end
            end
          end
        end else if (byte_q == ChBs) begin
          if (slot_free_i) begin
            res_o.valid = 1'b1;
            res_o.kind  = KindErase;
            res_o.cnt   = ERASE_W'(1);
            res_o.last  = 1'b1;
            if (fill_q != '0) begin
              fill_d = fill_m1;
            end
            state_d = StIdle;
          end
        end else if (byte_q == ChKill) begin
          if (slot_free_i) begin
            res_o.valid = 1'b1;
            res_o.kind  = KindErase;
            res_o.cnt   = ERASE_W'(fill_q);
            res_o.last  = 1'b1;
            fill_d      = '0;
            state_d     = StIdle;
          end
        end else if (byte_q == ChWerase) begin
          removed_d  = '0;
          space_ph_d = 1'b1;
          state_d    = StWwReq;
        end else if (byte_q >= ChSpace && byte_q <= ChTilde) begin
          if (slot_free_i) begin
            res_o.valid = 1'b1;
            res_o.kind  = KindEcho;
            res_o.ch    = byte_q;
            res_o.last  = 1'b1;
            if (fill_q < LineMax) begin
              mem_req_o.we    = 1'b1;
              mem_req_o.addr  = fill_q[IDX_W-1:0];
              mem_req_o.wdata = byte_q;
              fill_d          = fill_q + CntOne;
            end
            state_d = StIdle;
          end
        end else begin
          state_d = StIdle;
        end
      end

      // append LF if there is still room, then start streaming
      StAppLf: begin
        if (len_q < LineMax) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.addr  = len_q[IDX_W-1:0];
          mem_req_o.wdata = ChLf;
          len_d           = len_q + CntOne;
        end
        idx_d   = '0;
        state_d = StRdReq;
      end

      StRdReq: begin
        mem_req_o.re   = 1'b1;
        mem_req_o.addr = idx_q;
        state_d        = StRdEmit;
      end

      // one line char per cycle while the output slot is free; next read issued with each emit
      StRdEmit: begin
        if (slot_free_i) begin
          res_o.valid = 1'b1;
          res_o.kind  = KindLine;
          res_o.ch    = rdata_i;
          res_o.last  = rd_last;
          if (rd_last) begin
            fill_d  = '0;
            state_d = StIdle;
          end else begin
            mem_req_o.re   = 1'b1;
            mem_req_o.addr = idx_q + IDX_W'(1);
            idx_d          = idx_q + IDX_W'(1);
          end
        end
      end

      // erase word: read the char before the fill point
      StWwReq: begin
        if (fill_q == '0) begin
          state_d = StWwOut;
        end else begin
          mem_req_o.re   = 1'b1;
          mem_req_o.addr = fill_m1[IDX_W-1:0];
          state_d        = StWwChk;
        end
      end

      StWwChk: begin
        if (space_ph_q && is_sp) begin
          fill_d    = fill_m1;
          removed_d = removed_q + CntOne;
          state_d   = StWwReq;
        end else if (!is_sp) begin
          fill_d     = fill_m1;
          removed_d  = removed_q + CntOne;
          space_ph_d = 1'b0;
          state_d    = StWwReq;
        end else begin
          state_d = StWwOut;
        end
      end

      StWwOut: begin
        if (removed_q == '0) begin
          state_d = StIdle;
        end else if (slot_free_i) begin
          res_o.valid = 1'b1;
          res_o.kind  = KindErase;
          res_o.cnt   = ERASE_W'(removed_q);
          res_o.last  = 1'b1;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      fill_q     <= '0;
      len_q      <= '0;
      idx_q      <= '0;
      removed_q  <= '0;
      space_ph_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      len_q      <= len_d;
      idx_q      <= idx_d;
      removed_q  <= removed_d;
      space_ph_q <= space_ph_d;
    end
  end

  // byte register carries payload only
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign status_o.idle = (state_q == StIdle);
  assign status_o.fill = fill_q;

endmodule

// ===== sv/terminal_line_editor.sv =====
// Terminal line editor top level: sequencer, line store and output register.
// Each result is decoded from the registered byte and held in the output register.
// A new byte is accepted only while the sequencer is idle, after the previous byte's
// results are issued; a line end streams the line off the store's read port, one char
// per cycle while the output is free, and erase word walks back one char at a time.
// Reset clears the fill count and control; the line store itself is not cleared.
module terminal_line_editor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  byte_in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  kind_o,
  output logic [7:0]                  char_value_o,
  output logic [tle_pkg::ERASE_W-1:0] erase_count_o,
  output logic                        last_o
);
  import tle_pkg::*;

  mem_req_t           mem_req;
  res_t               res;
  status_t            status;
  logic [7:0]         rdata;
  logic               slot_free;

  logic               out_valid_q;
  kind_e              kind_q;
  logic [7:0]         char_q;
  logic [ERASE_W-1:0] cnt_q;
  logic               last_q;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = status.idle;

  tle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .byte_in_i   (byte_in_i),
    .slot_free_i (slot_free),
    .rdata_i     (rdata),
    .mem_req_o   (mem_req),
    .res_o       (res),
    .status_o    (status)
  );

  tle_line_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      kind_q <= res.kind;
      char_q <= res.ch;
      cnt_q  <= res.cnt;
      last_q <= res.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign char_value_o  = char_q;
  assign erase_count_o = cnt_q;
  assign last_o        = last_q;

  // a new result is only loaded into a free or draining slot
  a_res_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> slot_free)
    else $error("result issued into a busy output register");

  // fill count never runs past the line size
  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.fill <= CNT_W'(LINE_CHARS))
    else $error("fill count exceeds line size");

  // an accepted byte takes the sequencer out of idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !status.idle)
    else $error("sequencer stayed idle after accepting a byte");

  // erase and CRLF results carry no character
  a_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KindErase || kind_o == KindCrlf)) |-> (char_value_o == 8'd0))
    else $error("erase or CRLF result carries a character");

endmodule
